// ----- rtl/scancode_to_ascii_translator_unit_assert.svh -----
// Assertion macros for the scancode to ASCII translator checker.
`ifndef SCANCODE_TO_ASCII_TRANSLATOR_UNIT_ASSERT_SVH
`define SCANCODE_TO_ASCII_TRANSLATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SAT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SAT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/sat_pkg.sv -----
// Package: types, key codes and character table for the scancode translator.
package sat_pkg;

	localparam logic [7:0] PREFIX_BYTE = 8'hE0;
	localparam logic [7:0] TABLE_END   = 8'h3B;
	localparam logic [7:0] K_LSHIFT    = 8'h2A;
	localparam logic [7:0] K_RSHIFT    = 8'h36;
	localparam logic [7:0] K_CTRL      = 8'h1D;
	localparam logic [7:0] K_ALT       = 8'h38;
	localparam logic [7:0] K_CAPS      = 8'h3A;
	localparam logic [7:0] K_BACKTICK  = 8'h29;

	localparam logic [6:0] CH_LOWER_A = 7'h61;
	localparam logic [6:0] CH_LOWER_L = 7'h6C;
	localparam logic [6:0] CH_LOWER_U = 7'h75;

	typedef struct packed {
		logic ctrl;
		logic shift;
		logic alt;
		logic caps;
		logic prefix;
	} sat_flags_t;

	// Keys whose second column follows shift alone (digits, punctuation).
	function automatic logic shift_only_key(input logic [7:0] b);
		return (b < 8'h0E) || (b == K_BACKTICK) || (b == 8'h1A) || (b == 8'h1B) ||
			(b == 8'h2B) || (b == 8'h27) || (b == 8'h28) || (b == 8'h33) ||
			(b == 8'h34) || (b == 8'h35);
	endfunction

	// Returns the character for a table row and column; zero for modifiers.
	function automatic logic [6:0] char_lookup(input logic [5:0] idx, input logic col);
		logic [13:0] pair;
		case (idx)
			6'd1:  pair = {7'h1B, 7'h1B};
			6'd2:  pair = {7'h31, 7'h21};
			6'd3:  pair = {7'h32, 7'h40};
			6'd4:  pair = {7'h33, 7'h23};
			6'd5:  pair = {7'h34, 7'h24};
			6'd6:  pair = {7'h35, 7'h25};
			6'd7:  pair = {7'h36, 7'h5E};
			6'd8:  pair = {7'h37, 7'h26};
			6'd9:  pair = {7'h38, 7'h2A};
			6'd10: pair = {7'h39, 7'h28};
			6'd11: pair = {7'h30, 7'h29};
			6'd12: pair = {7'h2D, 7'h5F};
			6'd13: pair = {7'h3D, 7'h2B};
			6'd14: pair = {7'h08, 7'h08};
			6'd15: pair = {7'h09, 7'h09};
			6'd16: pair = {7'h71, 7'h51};
			6'd17: pair = {7'h77, 7'h57};
			6'd18: pair = {7'h65, 7'h45};
			6'd19: pair = {7'h72, 7'h52};
			6'd20: pair = {7'h74, 7'h54};
			6'd21: pair = {7'h79, 7'h59};
			6'd22: pair = {7'h75, 7'h55};
			6'd23: pair = {7'h69, 7'h49};
			6'd24: pair = {7'h6F, 7'h4F};
			6'd25: pair = {7'h70, 7'h50};
			6'd26: pair = {7'h5B, 7'h7B};
			6'd27: pair = {7'h5D, 7'h7D};
			6'd28: pair = {7'h0D, 7'h0D};
			6'd30: pair = {7'h61, 7'h41};
			6'd31: pair = {7'h73, 7'h53};
			6'd32: pair = {7'h64, 7'h44};
			6'd33: pair = {7'h66, 7'h46};
			6'd34: pair = {7'h67, 7'h47};
			6'd35: pair = {7'h68, 7'h48};
			6'd36: pair = {7'h6A, 7'h4A};
			6'd37: pair = {7'h6B, 7'h4B};
			6'd38: pair = {7'h6C, 7'h4C};
			6'd39: pair = {7'h3B, 7'h3A};
			6'd40: pair = {7'h27, 7'h22};
			6'd41: pair = {7'h60, 7'h7E};
			6'd43: pair = {7'h5C, 7'h7C};
			6'd44: pair = {7'h7A, 7'h5A};
			6'd45: pair = {7'h78, 7'h58};
			6'd46: pair = {7'h63, 7'h43};
			6'd47: pair = {7'h76, 7'h56};
			6'd48: pair = {7'h62, 7'h42};
			6'd49: pair = {7'h6E, 7'h4E};
			6'd50: pair = {7'h6D, 7'h4D};
			6'd51: pair = {7'h2C, 7'h3C};
			6'd52: pair = {7'h2E, 7'h3E};
			6'd53: pair = {7'h2F, 7'h3F};
			6'd55: pair = {7'h2A, 7'h2A};
			6'd57: pair = {7'h20, 7'h20};
			default: pair = 14'h0000;
		endcase
		return col ? pair[6:0] : pair[13:7];
	endfunction

endpackage

// ----- rtl/sat_xlate.sv -----
// Translation logic: one scan byte plus current flags to a character and next flags.
module sat_xlate
	import sat_pkg::*;
(
	input  logic [7:0]  scan_byte,
	input  sat_flags_t  flags,
	output sat_flags_t  flags_next,
	output logic        emit,
	output logic [6:0]  ch
);

	logic       ext;
	logic       in_table;
	logic       col;
	logic [6:0] ch_raw;
	logic [7:0] mk;

	assign ext = flags.prefix;
	assign mk  = {1'b0, scan_byte[6:0]};

	always_comb begin
		in_table = ext ? ((scan_byte == K_CTRL) || (scan_byte == K_ALT))
			: ((scan_byte != 8'h00) && (scan_byte < TABLE_END));
		col = (shift_only_key(scan_byte) && !ext) ? flags.shift : (flags.shift ^ flags.caps);
		ch_raw = char_lookup(scan_byte[5:0], col);
		ch = ch_raw;
		if (flags.ctrl && ((ch_raw == CH_LOWER_L) || (ch_raw == CH_LOWER_U))) begin
			ch = ch_raw - CH_LOWER_A;
		end
	end

	always_comb begin
		flags_next = flags;
		emit = 1'b0;
		if (scan_byte == PREFIX_BYTE) begin
			flags_next.prefix = 1'b1;
		end else begin
			flags_next.prefix = 1'b0;
			if (scan_byte[7]) begin
				if (mk == K_CTRL) begin
					flags_next.ctrl = 1'b0;
				end else if (!ext && ((mk == K_LSHIFT) || (mk == K_RSHIFT))) begin
					flags_next.shift = 1'b0;
				end else if (mk == K_ALT) begin
					flags_next.alt = 1'b0;
				end
			end else if (in_table) begin
				if (ch != 7'h00) begin
					emit = 1'b1;
				end else if (scan_byte == K_CTRL) begin
					flags_next.ctrl = 1'b1;
				end else if (!ext && ((scan_byte == K_LSHIFT) || (scan_byte == K_RSHIFT))) begin
					flags_next.shift = 1'b1;
				end else if (scan_byte == K_ALT) begin
					flags_next.alt = 1'b1;
				end else if (!ext && (scan_byte == K_CAPS)) begin
					flags_next.caps = ~flags.caps;
				end
			end
		end
	end

endmodule

// ----- rtl/scancode_to_ascii_translator_unit.sv -----
// Top level: set-1 scan byte to ASCII translator with modifier tracking.
// Each scan byte is registered on entry, translated in the following cycle against the
// ctrl, shift, alt, caps lock and 0xE0-prefix flags, and the character (if any) lands in
// the output register, which drives ascii_char. One item is taken every cycle, but a
// held result stalls the input only while the byte in the input register makes one too.
// Bytes that give no character (prefixes, breaks, modifiers, unknown codes) only update
// the flags and never wait on out_ready.
module scancode_to_ascii_translator_unit
	import sat_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] scan_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [6:0] ascii_char
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	sat_flags_t flags_q;
	sat_flags_t flags_next;
	logic       emit;
	logic [6:0] ch;
	logic       out_valid_q;
	logic [6:0] ascii_char_q;
	logic       out_free;
	logic       s1_done;

	sat_xlate u_xlate (
		.scan_byte  (byte_s1),
		.flags      (flags_q),
		.flags_next (flags_next),
		.emit       (emit),
		.ch         (ch)
	);

	assign out_free  = !out_valid_q || out_ready;
	assign s1_done   = valid_s1 && (!emit || out_free);
	assign in_ready  = !valid_s1 || s1_done;
	assign out_valid = out_valid_q;
	assign ascii_char = ascii_char_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			flags_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (s1_done) begin
				flags_q <= flags_next;
			end
			if (s1_done && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= scan_byte;
		end
		if (s1_done && emit) begin
			ascii_char_q <= ch;
		end
	end

endmodule

// ----- rtl/sat_checker.sv -----
// Port-level checker for the scancode translator, bound to the top level.
`include "scancode_to_ascii_translator_unit_assert.svh"

module sat_checker
	import sat_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] scan_byte,
	input logic       out_valid,
	input logic       out_ready,
	input logic [6:0] ascii_char
);

	`SAT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(ascii_char), "held item changed")
	`SAT_ASSERT_NOW(a_char_nonzero, out_valid, ascii_char != 7'h00, "zero character emitted")
	`SAT_ASSERT_NOW(a_rise_after_accept, $rose(out_valid),
		$past(in_valid && in_ready, 2), "item out of nowhere")
	`SAT_ASSERT_NOW(a_prefix_silent,
		$past(in_valid && in_ready && (scan_byte == PREFIX_BYTE), 2),
		!$rose(out_valid), "prefix byte gave an item")

endmodule

bind scancode_to_ascii_translator_unit sat_checker u_sat_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.scan_byte  (scan_byte),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.ascii_char (ascii_char)
);

// ----- tb/sv/scancode_to_ascii_translator_unit_test.sv -----
// Testbench for the set-1 scancode to ASCII translator: predicts characters and checks output.
module scancode_to_ascii_translator_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import sat_pkg::*;

	localparam logic [15:0] BREAK_BIT = 16'h0080;
	localparam logic [15:0] EXT_RCTRL = 16'hE01D;
	localparam logic [15:0] EXT_RALT  = 16'hE038;
	localparam logic [7:0]  BRK       = 8'h80;
	localparam logic [7:0]  K_ESC     = 8'h01;
	localparam logic [7:0]  K_ONE     = 8'h02;
	localparam logic [7:0]  K_Q       = 8'h10;
	localparam logic [7:0]  K_U       = 8'h16;
	localparam logic [7:0]  K_L       = 8'h26;

	class keymap_tracker;
		bit ctrl_on, shift_on, alt_on, caps_lock, ext_pending;
		bit [6:0] plain[59];
		bit [6:0] shifted[59];
		bit [6:0] pending_chars[$];
		int bytes_seen, chars_seen, caps_flips, ctrl_codes, errors;

		function new();
			plain = '{7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
				7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
				7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0D, 7'h00,
				7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
				7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
				7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00};
			shifted = '{7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
				7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
				7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0D, 7'h00,
				7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
				7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
				7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00};
		endfunction

		// digits and punctuation ignore caps lock
		function bit shift_only(bit [15:0] code);
			case (code)
				{8'h00, K_BACKTICK}, 16'h001A, 16'h001B, 16'h002B, 16'h0027, 16'h0028,
				16'h0033, 16'h0034, 16'h0035: return 1'b1;
				default: return code < 16'h000E;
			endcase
		endfunction

		function void note_byte(bit [7:0] b);
			bit [15:0] code;
			bit [15:0] mk;
			bit [6:0] ch;
			bit col;
			int idx;
			bytes_seen++;
			if (b == PREFIX_BYTE) begin
				ext_pending = 1'b1;
				return;
			end
			code = ext_pending ? {PREFIX_BYTE, b} : {8'h00, b};
			ext_pending = 1'b0;
			if ((code & BREAK_BIT) != 0) begin
				mk = code & ~BREAK_BIT;
				if (mk == K_CTRL || mk == EXT_RCTRL)
					ctrl_on = 1'b0;
				else if (mk == K_LSHIFT || mk == K_RSHIFT)
					shift_on = 1'b0;
				else if (mk == K_ALT || mk == EXT_RALT)
					alt_on = 1'b0;
				return;
			end
			if (!((code != 0 && code < TABLE_END) || code == EXT_RALT || code == EXT_RCTRL))
				return;
			idx = code[7:0] % 59;
			col = shift_only(code) ? shift_on : (shift_on ^ caps_lock);
			ch = col ? shifted[idx] : plain[idx];
			if (ctrl_on && (ch == CH_LOWER_L || ch == CH_LOWER_U)) begin
				ch = ch - CH_LOWER_A;
				ctrl_codes++;
			end
			if (ch != 0) begin
				pending_chars.push_back(ch);
				return;
			end
			if (code == K_CTRL || code == EXT_RCTRL)
				ctrl_on = 1'b1;
			else if (code == K_LSHIFT || code == K_RSHIFT)
				shift_on = 1'b1;
			else if (code == K_ALT || code == EXT_RALT)
				alt_on = 1'b1;
			else if (code == K_CAPS) begin
				caps_lock = !caps_lock;
				caps_flips++;
			end
		endfunction

		function void check_char(logic [6:0] got);
			bit [6:0] want;
			if (pending_chars.size() == 0) begin
				errors++;
				$display("%0t: unexpected ascii_char, expected none, got %h", $time, got);
				return;
			end
			want = pending_chars.pop_front();
			chars_seen++;
			if (got !== want) begin
				errors++;
				$display("%0t: ascii_char mismatch, expected %h, got %h", $time, want, got);
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] scan_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [6:0] ascii_char;

	keymap_tracker sb;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;

	scancode_to_ascii_translator_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.scan_byte (scan_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ascii_char(ascii_char)
	);

	always #10 clk = ~clk;

	// receiver: random stalls, or a long hold-off when requested
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_char(ascii_char);
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		scan_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_byte(b);
	endtask

	task automatic drain(input int max_cycles);
		int n;
		n = 0;
		in_valid <= 1'b0;
		while (sb.pending_chars.size() != 0 && n < max_cycles) begin
			@(posedge clk);
			n++;
		end
	endtask

	task automatic random_stroke();
		int r;
		logic [7:0] mod;
		r = $urandom_range(99);
		if (r < 45)
			send_byte(8'($urandom_range(1, K_CAPS)));
		else if (r < 60) begin
			case ($urandom_range(4))
				0: send_byte(K_LSHIFT | BRK);
				1: send_byte(K_RSHIFT | BRK);
				2: send_byte(K_CTRL | BRK);
				3: send_byte(K_ALT | BRK);
				default: send_byte(8'($urandom_range(8'h81, 8'hBA)));
			endcase
		end else if (r < 72) begin
			send_byte(PREFIX_BYTE);
			case ($urandom_range(4))
				0: send_byte(K_CTRL);
				1: send_byte(K_ALT);
				2: send_byte(K_CTRL | BRK);
				3: send_byte(K_ALT | BRK);
				default: send_byte(8'($urandom_range(255)));
			endcase
		end else if (r < 85) begin
			case ($urandom_range(2))
				0: mod = K_LSHIFT;
				1: mod = K_RSHIFT;
				default: mod = K_CTRL;
			endcase
			send_byte(mod);
			repeat ($urandom_range(1, 3)) begin
				case ($urandom_range(2))
					0: send_byte(K_L);
					1: send_byte(K_U);
					default: send_byte(8'($urandom_range(1, K_CAPS)));
				endcase
			end
			send_byte(mod | BRK);
		end else
			send_byte(8'($urandom_range(255)));
	endtask

	initial begin
		logic [7:0] opening[$];
		opening = '{8'h00, 8'hFF, K_ESC, K_CAPS, K_Q, K_ONE, K_LSHIFT, K_Q, K_ONE,
			K_LSHIFT | BRK, K_CAPS, K_CTRL, K_L, K_U, K_CAPS, K_L, K_CAPS, K_CTRL | BRK,
			PREFIX_BYTE, PREFIX_BYTE, K_ALT, PREFIX_BYTE, K_ALT | BRK, PREFIX_BYTE, K_CTRL,
			K_U, PREFIX_BYTE, K_Q, PREFIX_BYTE, K_CTRL | BRK, TABLE_END, BRK};
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening[i])
			send_byte(opening[i]);
		drain(1000);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
				default: begin send_idle_pct = 9; recv_stall_pct = 9; end
			endcase
			repeat (275)
				random_stroke();
			drain(20000);
		end

		// long receiver hold-off while keys from Q to L keep coming
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 300;
		repeat (60)
			send_byte(8'($urandom_range(K_Q, K_L)));
		drain(20000);

		repeat (8) @(posedge clk);
		$display("scanned %0d bytes across four idling phases and a hold-off burst;",
			sb.bytes_seen);
		$display("%0d characters checked, %0d caps toggles, %0d ctrl codes",
			sb.chars_seen, sb.caps_flips, sb.ctrl_codes);
		if (sb.errors == 0 && sb.pending_chars.size() == 0)
			$display("scancode_to_ascii_translator_unit_test passed");
		else begin
			if (sb.pending_chars.size() != 0)
				$display("%0t: %0d characters never arrived", $time, sb.pending_chars.size());
			$display("scancode_to_ascii_translator_unit_test failed");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("%0t: timeout", $time);
		$display("scancode_to_ascii_translator_unit_test failed");
		$finish;
	end

endmodule
